// ===== src/mkey_pkg.sv =====
package mkey_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_ALPHA_LO = 8'h41;
  localparam logic [7:0] CH_ALPHA_HI = 8'h5a;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS     = 8'h27;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_HYPHEN   = 8'h2d;
  localparam logic [7:0] CH_PERIOD   = 8'h2e;
  localparam logic [7:0] CH_QUEST    = 8'h3f;

  // element count and dah mask, first element sent in bit 0
  typedef struct packed {
    logic [2:0] count;
    logic [5:0] dahs;
  } code_t;

  localparam logic [8:0] DIGIT_TAB [0:9] = '{
    {3'd5, 6'd31}, {3'd5, 6'd30}, {3'd5, 6'd28}, {3'd5, 6'd24}, {3'd5, 6'd16},
    {3'd5, 6'd0},  {3'd5, 6'd1},  {3'd5, 6'd3},  {3'd5, 6'd7},  {3'd5, 6'd15}
  };

  localparam logic [8:0] ALPHA_TAB [0:25] = '{
    {3'd2, 6'd2},  {3'd4, 6'd1},  {3'd4, 6'd5},  {3'd3, 6'd1},  {3'd1, 6'd0},
    {3'd4, 6'd4},  {3'd3, 6'd3},  {3'd4, 6'd0},  {3'd2, 6'd0},  {3'd4, 6'd14},
    {3'd3, 6'd5},  {3'd4, 6'd2},  {3'd2, 6'd3},  {3'd2, 6'd1},  {3'd3, 6'd7},
    {3'd4, 6'd6},  {3'd4, 6'd11}, {3'd3, 6'd2},  {3'd3, 6'd0},  {3'd1, 6'd1},
    {3'd3, 6'd4},  {3'd4, 6'd8},  {3'd3, 6'd6},  {3'd4, 6'd9},  {3'd4, 6'd13},
    {3'd4, 6'd3}
  };

  function automatic code_t lookup_code(input logic [7:0] ch);
    logic [7:0] off_d;
    logic [7:0] off_a;
    code_t      res;
    off_d = ch - CH_DIGIT_LO;
    off_a = ch - CH_ALPHA_LO;
    res   = '0;
    if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) begin
      res = code_t'(DIGIT_TAB[off_d[3:0]]);
    end else if (ch >= CH_ALPHA_LO && ch <= CH_ALPHA_HI) begin
      res = code_t'(ALPHA_TAB[off_a[4:0]]);
    end else begin
      unique case (ch)
        CH_SPACE:  res = '{count: 3'd5, dahs: 6'd17};
        CH_DQUOTE: res = '{count: 3'd6, dahs: 6'd18};
        CH_APOS:   res = '{count: 3'd6, dahs: 6'd30};
        CH_LPAREN: res = '{count: 3'd5, dahs: 6'd13};
        CH_RPAREN: res = '{count: 3'd6, dahs: 6'd45};
        CH_COMMA:  res = '{count: 3'd6, dahs: 6'd51};
        CH_HYPHEN: res = '{count: 3'd6, dahs: 6'd33};
        CH_PERIOD: res = '{count: 3'd6, dahs: 6'd42};
        CH_QUEST:  res = '{count: 3'd6, dahs: 6'd12};
        default:   res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== src/morse_character_keyer.sv =====
// a character taken is queued, loaded into the serializer, then its units registered out
// throughput: one dot unit per cycle unless out_tready stalls it, 3 to 26 units
// per character, set by the unit serializer; characters follow with no gap while
// the queue has entries; a code outside the table is taken and gives no beat
// reset (synchronous, active low) empties the queue and the serializer
module morse_character_keyer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // key_on, zero fill
  output logic       out_tlast   // last_unit
);
  import mkey_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  code_t q_wdata;
  code_t q_rdata;

  mkey_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mkey_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  mkey_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_known: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.count != 3'd0) && !q_full)
    else $error("queue took an empty code or overflowed");

  a_last_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[0] == 1'b0)
    else $error("final unit of a character keyed on");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("nonzero fill bits in output beat");

endmodule

// ===== src/mkey_front.sv =====
module mkey_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // char_code
  input  logic                 q_full,
  output logic                 q_push,
  output mkey_pkg::code_t      q_wdata
);
  import mkey_pkg::*;

  code_t code;

  always_comb begin
    code      = lookup_code(in_tdata);
    in_tready = !q_full;
    q_wdata   = code;
    // unknown codes are taken and dropped
    q_push    = in_tvalid && !q_full && (code.count != 3'd0);
  end

endmodule

// ===== src/mkey_fifo.sv =====
module mkey_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mkey_pkg::code_t  wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output mkey_pkg::code_t  rdata
);
  import mkey_pkg::*;

  code_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   cnt_r;
  logic [QCW-1:0]   cnt_nxt;

  assign full   = (cnt_r == QCW'(QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/mkey_back.sv =====
module mkey_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mkey_pkg::code_t  q_rdata,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // key_on, zero fill
  output logic             out_tlast   // last_unit
);
  import mkey_pkg::*;

  logic       active_r, active_nxt;
  logic [5:0] dahs_r,   dahs_nxt;
  logic [2:0] left_r,   left_nxt;
  logic [2:0] unit_r,   unit_nxt;
  logic       ov_r,     ov_nxt;
  logic       key_r,    key_nxt;
  logic       last_r,   last_nxt;
  logic       adv;
  logic [2:0] unit_end;
  logic       elem_end;
  logic       char_end;

  always_comb begin
    adv      = active_r && (!ov_r || out_tready);
    unit_end = dahs_r[0] ? 3'd4 : 3'd2;
    elem_end = (unit_r == unit_end);
    char_end = elem_end && (left_r == 3'd1);
    q_pop    = q_valid && (!active_r || (adv && char_end));

    active_nxt = active_r;
    dahs_nxt   = dahs_r;
    left_nxt   = left_r;
    unit_nxt   = unit_r;
    ov_nxt     = ov_r && !out_tready;
    key_nxt    = key_r;
    last_nxt   = last_r;

    if (adv) begin
      ov_nxt   = 1'b1;
      key_nxt  = (unit_r != 3'd0) && !elem_end;
      last_nxt = char_end;
      if (elem_end) begin
        unit_nxt = '0;
        dahs_nxt = dahs_r >> 1;
        left_nxt = left_r - 1'b1;
        if (char_end) begin
          active_nxt = 1'b0;
        end
      end else begin
        unit_nxt = unit_r + 1'b1;
      end
    end

    if (q_pop) begin
      active_nxt = 1'b1;
      dahs_nxt   = q_rdata.dahs;
      left_nxt   = q_rdata.count;
      unit_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
    dahs_r <= dahs_nxt;
    left_r <= left_nxt;
    unit_r <= unit_nxt;
    key_r  <= key_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, key_r};
  assign out_tlast  = last_r;

endmodule
